// ===== hw/rtl/lpa_pkg.sv =====
// Shared types, constants and field layouts for the light pattern animator.
// No dependencies; the design files refer to this package by scoped names.

package lpa_pkg;

	// Sizes of the style table and of the time format
	localparam int SLOTS          = 64;
	localparam int PATTERN_MAX    = 64;
	localparam int TIME_FRAC_BITS = 10;

	// Fixed field widths of the stream beats
	localparam int OP_W   = 2;
	localparam int SLOT_W = 6;
	localparam int POS_W  = 6;
	localparam int SYM_W  = 8;
	localparam int LEN_W  = 6;
	localparam int RATE_W = 8;
	localparam int TIME_W = 32;
	localparam int LVL_W  = 23;

	localparam int IN_DATA_W  = 72;
	localparam int IN_USER_W  = OP_W;
	localparam int OUT_DATA_W = 32;
	localparam int IN_PAD_W   = IN_DATA_W - (SLOT_W + POS_W + SYM_W + LEN_W + RATE_W + 1 + TIME_W);
	localparam int OUT_PAD_W  = OUT_DATA_W - (LVL_W + SLOT_W);

	// Table addressing
	localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int PAT_DEPTH  = SLOTS * PATTERN_MAX;
	localparam int PAT_ADDR_W = $clog2(PAT_DEPTH);

	// Frame counter and remainder pipeline
	localparam int FRAME_W    = TIME_W + RATE_W;
	localparam int WHOLE_W    = FRAME_W - TIME_FRAC_BITS;
	localparam int MOD_STEP   = 5;
	localparam int MOD_STAGES = (WHOLE_W + MOD_STEP - 1) / MOD_STEP;
	localparam int MOD_PAD_W  = MOD_STAGES * MOD_STEP;

	// Brightness arithmetic
	localparam int DARKEST_CHAR   = 97;
	localparam int STEP_SCALE     = 22;
	localparam int DEFAULT_RATE   = 10;
	localparam int FULL_LEVEL     = 262144;
	localparam int LEVEL_MIN      = -2185216;
	localparam int LEVEL_MAX      = 3559424;
	localparam int OUT_SCALE_BITS = 10;
	localparam int STEP_W         = 14;
	localparam int DIFF_W         = STEP_W + 1;
	localparam int PROD_W         = DIFF_W + TIME_FRAC_BITS + 1;
	localparam int SUM_W          = PROD_W + 1;
	localparam int SCALED_W       = SUM_W + OUT_SCALE_BITS;
	localparam int OUT_SHL = (TIME_FRAC_BITS <= OUT_SCALE_BITS) ? OUT_SCALE_BITS - TIME_FRAC_BITS : 0;
	localparam int OUT_SHR = (TIME_FRAC_BITS >  OUT_SCALE_BITS) ? TIME_FRAC_BITS - OUT_SCALE_BITS : 0;

	// Result queue
	localparam int FIFO_DEPTH = 16;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [OP_W-1:0] {
		OP_WRITE  = 2'd0,
		OP_HEADER = 2'd1,
		OP_EVAL   = 2'd2
	} op_t;

	// Input tdata layout, last member in the lowest bits
	typedef struct packed {
		logic [IN_PAD_W-1:0] pad;
		logic [TIME_W-1:0]   time_now;
		logic                blend;
		logic [RATE_W-1:0]   frame_rate;
		logic [LEN_W-1:0]    pattern_length;
		logic [SYM_W-1:0]    symbol;
		logic [POS_W-1:0]    position;
		logic [SLOT_W-1:0]   slot;
	} in_data_t;

	// Slot header as stored in the header memory
	typedef struct packed {
		logic [LEN_W-1:0]  len;
		logic [RATE_W-1:0] rate;
		logic              blend;
	} hdr_t;

	// Item state carried down the pipeline
	typedef struct packed {
		logic                      vld;
		logic [OP_W-1:0]           op;
		logic [SLOT_W-1:0]         slot;
		logic [POS_W-1:0]          pos;
		logic [SYM_W-1:0]          symbol;
		logic [LEN_W-1:0]          len;
		logic                      blend;
		logic                      defined;
		logic [TIME_FRAC_BITS-1:0] frac;
	} pipe_t;

	// One result beat, level in the lowest bits
	typedef struct packed {
		logic [SLOT_W-1:0]       slot_out;
		logic signed [LVL_W-1:0] level;
	} res_t;

endpackage

// ===== hw/rtl/lpa_hdr_table.sv =====
// Slot header memory with per-slot defined bits for the light pattern animator.
// Depends on lpa_pkg for the header type and table sizes.

module lpa_hdr_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [lpa_pkg::SLOT_IDX_W-1:0] wr_slot,
	input  lpa_pkg::hdr_t                 wr_hdr,
	input  logic [lpa_pkg::SLOT_IDX_W-1:0] rd_slot,
	output lpa_pkg::hdr_t                 rd_hdr,
	output logic                          rd_defined
);

	lpa_pkg::hdr_t                mem [lpa_pkg::SLOTS];
	logic [lpa_pkg::SLOTS-1:0]    defined_q;
	lpa_pkg::hdr_t                rd_hdr_q;
	logic                         rd_defined_q;

	// Header storage, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_slot] <= wr_hdr;
		end
		rd_hdr_q <= mem[rd_slot];
	end

	// Defined bits stand in for the cleared header table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			defined_q    <= '0;
			rd_defined_q <= 1'b0;
		end else begin
			if (wr_en) begin
				defined_q[wr_slot] <= 1'b1;
			end
			rd_defined_q <= defined_q[rd_slot];
		end
	end

	assign rd_hdr     = rd_hdr_q;
	assign rd_defined = rd_defined_q;

endmodule

// ===== hw/rtl/lpa_mod_pipe.sv =====
// Pipelined remainder of the whole frame number by the pattern length.
// Depends on lpa_pkg; MOD_STEP dividend bits are retired per stage.

module lpa_mod_pipe (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lpa_pkg::pipe_t              in_item,
	input  logic [lpa_pkg::WHOLE_W-1:0] in_whole,
	output lpa_pkg::pipe_t              out_item,
	output logic [lpa_pkg::LEN_W-1:0]   out_rem
);

	lpa_pkg::pipe_t                       item_q  [lpa_pkg::MOD_STAGES];
	logic [lpa_pkg::LEN_W-1:0]            rem_q   [lpa_pkg::MOD_STAGES];
	logic [lpa_pkg::MOD_PAD_W-1:0]        whole_q [lpa_pkg::MOD_STAGES];

	lpa_pkg::pipe_t                       src_item  [lpa_pkg::MOD_STAGES];
	logic [lpa_pkg::LEN_W-1:0]            src_rem   [lpa_pkg::MOD_STAGES];
	logic [lpa_pkg::MOD_PAD_W-1:0]        src_whole [lpa_pkg::MOD_STAGES];
	logic [lpa_pkg::LEN_W-1:0]            rem_d     [lpa_pkg::MOD_STAGES];

	// Restoring remainder steps: the partial remainder stays below the divisor,
	// so each step needs one compare and one subtract.
	always_comb begin
		logic [lpa_pkg::LEN_W-1:0] dvs;
		logic [lpa_pkg::LEN_W:0]   part;
		for (int k = 0; k < lpa_pkg::MOD_STAGES; k++) begin
			if (k == 0) begin
				src_item[k]  = in_item;
				src_rem[k]   = '0;
				src_whole[k] = lpa_pkg::MOD_PAD_W'(in_whole);
			end else begin
				src_item[k]  = item_q[k-1];
				src_rem[k]   = rem_q[k-1];
				src_whole[k] = whole_q[k-1];
			end
			// empty pattern: any divisor will do, the result is overridden later
			dvs  = (src_item[k].len == '0) ? lpa_pkg::LEN_W'(1) : src_item[k].len;
			part = {1'b0, src_rem[k]};
			for (int b = 0; b < lpa_pkg::MOD_STEP; b++) begin
				part = {part[lpa_pkg::LEN_W-1:0],
					src_whole[k][lpa_pkg::MOD_PAD_W-1-k*lpa_pkg::MOD_STEP-b]};
				if (part >= {1'b0, dvs}) begin
					part = part - {1'b0, dvs};
				end
			end
			rem_d[k] = part[lpa_pkg::LEN_W-1:0];
		end
	end

	// Stage registers, item control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < lpa_pkg::MOD_STAGES; k++) begin
				item_q[k] <= '0;
			end
		end else begin
			for (int k = 0; k < lpa_pkg::MOD_STAGES; k++) begin
				item_q[k] <= src_item[k];
			end
		end
	end

	// Stage registers, arithmetic payload
	always_ff @(posedge clk) begin
		for (int k = 0; k < lpa_pkg::MOD_STAGES; k++) begin
			rem_q[k]   <= rem_d[k];
			whole_q[k] <= src_whole[k];
		end
	end

	assign out_item = item_q[lpa_pkg::MOD_STAGES-1];
	assign out_rem  = rem_q[lpa_pkg::MOD_STAGES-1];

endmodule

// ===== hw/rtl/lpa_pattern_ram.sv =====
// Pattern character memory: one write port and two registered read ports.
// Depends on lpa_pkg for depth and widths; contents are undefined until written.

module lpa_pattern_ram (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [lpa_pkg::PAT_ADDR_W-1:0] wr_addr,
	input  logic [lpa_pkg::SYM_W-1:0]      wr_data,
	input  logic [lpa_pkg::PAT_ADDR_W-1:0] rd_addr_a,
	input  logic [lpa_pkg::PAT_ADDR_W-1:0] rd_addr_b,
	output logic [lpa_pkg::SYM_W-1:0]      rd_data_a,
	output logic [lpa_pkg::SYM_W-1:0]      rd_data_b
);

	logic [lpa_pkg::SYM_W-1:0] mem [lpa_pkg::PAT_DEPTH];
	logic [lpa_pkg::SYM_W-1:0] rd_a_q;
	logic [lpa_pkg::SYM_W-1:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_a_q <= mem[rd_addr_a];
		rd_b_q <= mem[rd_addr_b];
	end

	assign rd_data_a = rd_a_q;
	assign rd_data_b = rd_b_q;

endmodule

// ===== hw/rtl/lpa_out_fifo.sv =====
// Result queue between the evaluation pipeline and the master stream port.
// Depends on lpa_pkg for the result type and depth; the top level never overfills it.

module lpa_out_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lpa_pkg::res_t push_data,
	input  logic          pop,
	output logic          out_valid,
	output lpa_pkg::res_t out_data
);

	lpa_pkg::res_t                 mem [lpa_pkg::FIFO_DEPTH];
	logic [lpa_pkg::FIFO_PTR_W-1:0] wr_ptr_q;
	logic [lpa_pkg::FIFO_PTR_W-1:0] rd_ptr_q;
	logic [lpa_pkg::FIFO_CNT_W-1:0] cnt_q;

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + lpa_pkg::FIFO_CNT_W'(push) - lpa_pkg::FIFO_CNT_W'(pop);
		end
	end

	assign out_valid = (cnt_q != '0);
	assign out_data  = mem[rd_ptr_q];

endmodule

// ===== hw/rtl/light_pattern_animator.sv =====
// Top level of the light pattern animator: header table, frame multiply,
// remainder pipeline, pattern memory, blend arithmetic and result queue.
// Depends on lpa_pkg, lpa_hdr_table, lpa_mod_pipe, lpa_pattern_ram, lpa_out_fifo.
//
//  port group  direction  beat contents (low bits first)
//  s_*         in         tuser: operation; tdata: slot, position, symbol,
//                         pattern_length, frame_rate, blend, time_now
//  m_*         out        tdata: level, slot_out (evaluate items only)
//
// One item is taken per clock while s_tready is high. An evaluate result passes
// header read, frame multiply, remainder pipeline (one stage per five frame bits),
// pattern read, blend stages and queue registers before it reaches m_tvalid.
// s_tready drops only once FIFO_DEPTH results are owed, so m_tready may stall
// for a while without slowing the input. Reset clears the defined bits and the
// queue; no clearing pass runs over the memories.

module light_pattern_animator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// slot, position, symbol, pattern_length, frame_rate, blend, time_now, zero pad
	input  logic [lpa_pkg::IN_DATA_W-1:0]  s_tdata,
	// operation
	input  logic [lpa_pkg::IN_USER_W-1:0]  s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// level, slot_out, zero pad
	output logic [lpa_pkg::OUT_DATA_W-1:0] m_tdata
);

	lpa_pkg::in_data_t in_beat;
	lpa_pkg::pipe_t    item_in;
	logic              acc;
	logic              acc_eval;
	logic              pop;
	logic [lpa_pkg::FIFO_CNT_W-1:0] owed_q;

	lpa_pkg::pipe_t            item_s1;
	logic [lpa_pkg::TIME_W-1:0] time_s1;
	lpa_pkg::hdr_t             hdr_rd;
	logic                      hdr_defined;
	logic                      hdr_wr_en;
	lpa_pkg::hdr_t             hdr_wr;

	lpa_pkg::pipe_t              item_s2_d;
	logic [lpa_pkg::RATE_W-1:0]  rate_eff;
	logic [lpa_pkg::FRAME_W-1:0] frame;
	lpa_pkg::pipe_t              item_s2;
	logic [lpa_pkg::WHOLE_W-1:0] whole_s2;

	lpa_pkg::pipe_t              item_s3;
	logic [lpa_pkg::LEN_W-1:0]   idx_a;
	logic [lpa_pkg::LEN_W:0]     idx_a_inc;
	logic [lpa_pkg::LEN_W-1:0]   idx_b;
	logic                        pat_wr_en;
	logic [lpa_pkg::PAT_ADDR_W-1:0] pat_wr_addr;
	logic [lpa_pkg::PAT_ADDR_W-1:0] pat_rd_addr_a;
	logic [lpa_pkg::PAT_ADDR_W-1:0] pat_rd_addr_b;

	lpa_pkg::pipe_t              item_s4;
	logic [lpa_pkg::SYM_W-1:0]   char_a;
	logic [lpa_pkg::SYM_W-1:0]   char_b;

	logic signed [lpa_pkg::STEP_W-1:0] step_a;
	logic signed [lpa_pkg::STEP_W-1:0] step_b;
	lpa_pkg::pipe_t                    item_s5_d;
	lpa_pkg::pipe_t                    item_s5;
	logic signed [lpa_pkg::STEP_W-1:0] step_a_s5;
	logic signed [lpa_pkg::DIFF_W-1:0] diff_s5;

	lpa_pkg::pipe_t                      item_s6;
	logic signed [lpa_pkg::STEP_W-1:0]   step_a_s6;
	logic signed [lpa_pkg::PROD_W-1:0]   prod_s6;
	logic signed [lpa_pkg::SUM_W-1:0]    sum;
	logic signed [lpa_pkg::SCALED_W-1:0] scaled;
	lpa_pkg::res_t                       res;
	logic                                push;
	lpa_pkg::res_t                       fifo_data;

	// Input beat decode
	assign in_beat  = lpa_pkg::in_data_t'(s_tdata);
	assign acc      = s_tvalid && s_tready;
	assign acc_eval = acc && (s_tuser == lpa_pkg::OP_EVAL);
	assign pop      = m_tvalid && m_tready;

	always_comb begin
		item_in         = '0;
		item_in.vld     = acc;
		item_in.op      = s_tuser;
		item_in.slot    = in_beat.slot;
		item_in.pos     = in_beat.position;
		item_in.symbol  = in_beat.symbol;
	end

	// Results owed: accepted evaluates not yet taken from the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_q <= '0;
		end else begin
			owed_q <= owed_q + lpa_pkg::FIFO_CNT_W'(acc_eval) - lpa_pkg::FIFO_CNT_W'(pop);
		end
	end

	assign s_tready = (owed_q < lpa_pkg::FIFO_CNT_W'(lpa_pkg::FIFO_DEPTH));

	// Header write at accept; a too long header is dropped
	assign hdr_wr_en = acc && (s_tuser == lpa_pkg::OP_HEADER)
		&& (int'(in_beat.slot) < lpa_pkg::SLOTS)
		&& (int'(in_beat.pattern_length) + 1 < lpa_pkg::PATTERN_MAX);

	always_comb begin
		hdr_wr.len   = in_beat.pattern_length;
		hdr_wr.rate  = in_beat.frame_rate;
		hdr_wr.blend = in_beat.blend;
	end

	lpa_hdr_table u_hdr (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (hdr_wr_en),
		.wr_slot    (lpa_pkg::SLOT_IDX_W'(in_beat.slot)),
		.wr_hdr     (hdr_wr),
		.rd_slot    (lpa_pkg::SLOT_IDX_W'(in_beat.slot)),
		.rd_hdr     (hdr_rd),
		.rd_defined (hdr_defined)
	);

	// Stage 1: item beside the header read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else begin
			item_s1 <= item_in;
		end
	end

	always_ff @(posedge clk) begin
		time_s1 <= in_beat.time_now;
	end

	// Frame number = time * rate, rate 0 selects the default
	always_comb begin
		rate_eff  = (hdr_rd.rate == '0) ? lpa_pkg::RATE_W'(lpa_pkg::DEFAULT_RATE) : hdr_rd.rate;
		frame     = lpa_pkg::FRAME_W'(time_s1) * lpa_pkg::FRAME_W'(rate_eff);
		item_s2_d = item_s1;
		item_s2_d.len     = hdr_rd.len;
		item_s2_d.blend   = hdr_rd.blend;
		item_s2_d.defined = hdr_defined && (int'(item_s1.slot) < lpa_pkg::SLOTS);
		item_s2_d.frac    = frame[lpa_pkg::TIME_FRAC_BITS-1:0];
	end

	// Stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s2 <= '0;
		end else begin
			item_s2 <= item_s2_d;
		end
	end

	always_ff @(posedge clk) begin
		whole_s2 <= frame[lpa_pkg::FRAME_W-1:lpa_pkg::TIME_FRAC_BITS];
	end

	lpa_mod_pipe u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (item_s2),
		.in_whole (whole_s2),
		.out_item (item_s3),
		.out_rem  (idx_a)
	);

	// Neighbor index wraps at the length
	always_comb begin
		idx_a_inc = {1'b0, idx_a} + 1'b1;
		idx_b     = (idx_a_inc == {1'b0, item_s3.len}) ? '0 : idx_a_inc[lpa_pkg::LEN_W-1:0];
	end

	// Pattern writes travel with the evaluates so both see the store in item order
	assign pat_wr_en = item_s3.vld && (item_s3.op == lpa_pkg::OP_WRITE)
		&& (int'(item_s3.slot) < lpa_pkg::SLOTS)
		&& (int'(item_s3.pos) < lpa_pkg::PATTERN_MAX);
	assign pat_wr_addr   = lpa_pkg::PAT_ADDR_W'(int'(item_s3.slot) * lpa_pkg::PATTERN_MAX
		+ int'(item_s3.pos));
	assign pat_rd_addr_a = lpa_pkg::PAT_ADDR_W'(int'(item_s3.slot) * lpa_pkg::PATTERN_MAX
		+ int'(idx_a));
	assign pat_rd_addr_b = lpa_pkg::PAT_ADDR_W'(int'(item_s3.slot) * lpa_pkg::PATTERN_MAX
		+ int'(idx_b));

	lpa_pattern_ram u_pat (
		.clk       (clk),
		.wr_en     (pat_wr_en),
		.wr_addr   (pat_wr_addr),
		.wr_data   (item_s3.symbol),
		.rd_addr_a (pat_rd_addr_a),
		.rd_addr_b (pat_rd_addr_b),
		.rd_data_a (char_a),
		.rd_data_b (char_b)
	);

	// Stage 4: item beside the character read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s4 <= '0;
		end else begin
			item_s4 <= item_s3;
		end
	end

	// Characters to brightness steps
	always_comb begin
		step_a = lpa_pkg::STEP_W'(($signed({1'b0, char_a}) - lpa_pkg::DARKEST_CHAR)
			* lpa_pkg::STEP_SCALE);
		step_b = lpa_pkg::STEP_W'(($signed({1'b0, char_b}) - lpa_pkg::DARKEST_CHAR)
			* lpa_pkg::STEP_SCALE);
	end

	// Stage 5: blend as a + (b - a) * f; stepping uses f = 0
	always_comb begin
		item_s5_d = item_s4;
		if (!item_s4.blend) begin
			item_s5_d.frac = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s5 <= '0;
		end else begin
			item_s5 <= item_s5_d;
		end
	end

	always_ff @(posedge clk) begin
		step_a_s5 <= step_a;
		diff_s5   <= lpa_pkg::DIFF_W'(step_b) - lpa_pkg::DIFF_W'(step_a);
	end

	// Stage 6: fraction product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s6 <= '0;
		end else begin
			item_s6 <= item_s5;
		end
	end

	always_ff @(posedge clk) begin
		step_a_s6 <= step_a_s5;
		prod_s6   <= lpa_pkg::PROD_W'(diff_s5)
			* lpa_pkg::PROD_W'($signed({1'b0, item_s5.frac}));
	end

	// Sum, output scaling (floor) and the undefined / empty cases
	always_comb begin
		sum    = (lpa_pkg::SUM_W'(step_a_s6) <<< lpa_pkg::TIME_FRAC_BITS)
			+ lpa_pkg::SUM_W'(prod_s6);
		scaled = (lpa_pkg::SCALED_W'(sum) <<< lpa_pkg::OUT_SHL) >>> lpa_pkg::OUT_SHR;
		res.slot_out = item_s6.slot;
		if (!item_s6.defined) begin
			res.level = '0;
		end else if (item_s6.len == '0) begin
			res.level = lpa_pkg::LVL_W'(lpa_pkg::FULL_LEVEL);
		end else begin
			res.level = scaled[lpa_pkg::LVL_W-1:0];
		end
	end

	assign push = item_s6.vld && (item_s6.op == lpa_pkg::OP_EVAL);

	lpa_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_data  (fifo_data)
	);

	assign m_tdata = {lpa_pkg::OUT_PAD_W'(0), fifo_data};

endmodule

// ===== hw/rtl/lpa_checker.sv =====
// Port-level checks for the light pattern animator, bound to the top level.
// Depends on lpa_pkg for widths and level limits.

module lpa_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [lpa_pkg::OUT_DATA_W-1:0] m_tdata
);

	// A stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// Pad bits above slot_out stay zero
	a_out_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[lpa_pkg::OUT_DATA_W-1:lpa_pkg::LVL_W+lpa_pkg::SLOT_W] == '0)
		else $error("result pad bits not zero");

	// Level stays in the reachable brightness range
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[lpa_pkg::LVL_W-1:0]) >= lpa_pkg::LEVEL_MIN)
			&& ($signed(m_tdata[lpa_pkg::LVL_W-1:0]) <= lpa_pkg::LEVEL_MAX))
		else $error("level out of range");

	// Out of reset the block is empty and ready
	a_reset_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> s_tready && !m_tvalid)
		else $error("not idle after reset");

endmodule

bind light_pattern_animator lpa_checker u_lpa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== test/tb_light_pattern_animator.sv =====
`timescale 1ns / 1ps
// Testbench for light_pattern_animator: streams pattern writes, slot headers and
// evaluate beats, predicts every brightness result and checks the output stream.
// Depends on lpa_pkg and the light_pattern_animator RTL.

// Brightness predictor and store of owed results
class lpa_brightness_board;
	bit [lpa_pkg::SYM_W-1:0]  glyph     [lpa_pkg::SLOTS][lpa_pkg::PATTERN_MAX];
	bit                       glyph_set [lpa_pkg::SLOTS][lpa_pkg::PATTERN_MAX];
	bit [lpa_pkg::LEN_W-1:0]  hdr_len   [lpa_pkg::SLOTS];
	bit [lpa_pkg::RATE_W-1:0] hdr_rate  [lpa_pkg::SLOTS];
	bit                       hdr_blend [lpa_pkg::SLOTS];
	bit                       hdr_valid [lpa_pkg::SLOTS];
	lpa_pkg::res_t            owed[$];
	int errors, checked, n_dark, n_full, n_step, n_blend;

	function longint step_of(int unsigned s, longint unsigned i);
		longint c;
		c = glyph[s][i];
		return (c - lpa_pkg::DARKEST_CHAR) * lpa_pkg::STEP_SCALE;
	endfunction

	function logic [lpa_pkg::LVL_W-1:0] level_at(int unsigned s, logic [31:0] t);
		longint unsigned frame, whole, i1, i2, len, rate;
		longint frac, one, v1, v2, sum;
		if (!hdr_valid[s]) begin
			n_dark++;
			return '0;
		end
		if (hdr_len[s] == 0) begin
			n_full++;
			return lpa_pkg::LVL_W'(lpa_pkg::FULL_LEVEL);
		end
		len   = hdr_len[s];
		rate  = (hdr_rate[s] == 0) ? lpa_pkg::DEFAULT_RATE : hdr_rate[s];
		frame = t;
		frame = frame * rate;
		whole = frame >> lpa_pkg::TIME_FRAC_BITS;
		frac  = longint'(frame & ((64'd1 << lpa_pkg::TIME_FRAC_BITS) - 64'd1));
		one   = longint'(1) << lpa_pkg::TIME_FRAC_BITS;
		i1    = whole % len;
		v1    = step_of(s, i1);
		if (!hdr_blend[s]) begin
			n_step++;
			sum = v1 * one;
		end else begin
			// mix with the next step, wrapping at the pattern end
			n_blend++;
			i2  = (whole + 1) % len;
			v2  = step_of(s, i2);
			sum = v1 * (one - frac) + v2 * frac;
		end
		// rescale to 1/262144; a right shift floors negative sums
		sum = (sum <<< lpa_pkg::OUT_SHL) >>> lpa_pkg::OUT_SHR;
		return sum[lpa_pkg::LVL_W-1:0];
	endfunction

	// Update the table copy for an accepted input beat
	function void note(logic [lpa_pkg::OP_W-1:0] op, lpa_pkg::in_data_t d);
		lpa_pkg::res_t r;
		case (op)
			lpa_pkg::OP_WRITE: begin
				glyph[d.slot][d.position]     = d.symbol;
				glyph_set[d.slot][d.position] = 1'b1;
			end
			lpa_pkg::OP_HEADER: begin
				// too-long headers leave the old header in place
				if (int'(d.pattern_length) + 1 < lpa_pkg::PATTERN_MAX) begin
					hdr_len[d.slot]   = d.pattern_length;
					hdr_rate[d.slot]  = d.frame_rate;
					hdr_blend[d.slot] = d.blend;
					hdr_valid[d.slot] = 1'b1;
				end
			end
			lpa_pkg::OP_EVAL: begin
				r.slot_out = d.slot;
				r.level    = level_at(d.slot, d.time_now);
				owed.push_back(r);
			end
			default: ;
		endcase
	endfunction

	// Compare a result beat with the oldest owed result
	function void check(lpa_pkg::res_t got);
		lpa_pkg::res_t want;
		if (owed.size() == 0) begin
			$error("result beat with nothing owed: level %0d slot_out %0d",
				got.level, got.slot_out);
			errors++;
			return;
		end
		want = owed.pop_front();
		checked++;
		if (got.level !== want.level) begin
			$error("level: expected %0d, actual %0d", want.level, got.level);
			errors++;
		end
		if (got.slot_out !== want.slot_out) begin
			$error("slot_out: expected %0d, actual %0d", want.slot_out, got.slot_out);
			errors++;
		end
	endfunction

	// First unwritten character a read of this slot would touch, or -1
	function int missing_char(int unsigned s);
		if (!hdr_valid[s])
			return -1;
		for (int i = 0; i < int'(hdr_len[s]); i++)
			if (!glyph_set[s][i])
				return i;
		return -1;
	endfunction
endclass

module tb_light_pattern_animator;
	import lpa_pkg::*;

	localparam logic [OP_W-1:0] OP_NONE = 2'd3;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_ITEMS   = 1450;
	localparam int TAIL_ITEMS     = 120;
	localparam int SETTLE_CYCLES  = 40;
	localparam int RX_HOLD_AT     = 150;
	localparam int RX_HOLD_CYCLES = 300;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;   // slot, position, symbol, pattern_length, frame_rate, blend, time_now
	logic [IN_USER_W-1:0]  s_tuser;   // operation
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;   // level, slot_out

	lpa_brightness_board board = new();
	bit quiet;
	bit tx_calm;
	int tx_phase;
	int sent;
	int beats;

	light_pattern_animator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog: ends the run when no beat moves for too long
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid === 1'b1 && s_tready === 1'b1) ||
			    (m_tvalid === 1'b1 && m_tready === 1'b1))
				idle = 0;
			else
				idle++;
		end
		$display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
		$display("** light_pattern_animator: FAILED **");
		$finish;
	end

	// Result side: check beats, stall in random bursts, one long hold-off
	initial begin : receiver
		int stall, phase, results;
		bit calm;
		stall   = 0;
		phase   = 0;
		calm    = 1'b0;
		results = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
				board.check(res_t'(m_tdata[LVL_W+SLOT_W-1:0]));
				results++;
				// long hold so the queue fills and the input backs up
				if (results == RX_HOLD_AT)
					stall = RX_HOLD_CYCLES;
			end
			if (phase == 0) begin
				phase = $urandom_range(20, 150);
				calm  = ($urandom_range(0, 2) == 0);
			end
			phase--;
			if (stall == 0 && !quiet && !calm && $urandom_range(0, 9) == 0)
				stall = $urandom_range(1, 13);
			if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic in_data_t rand_fields();
		logic [95:0] raw;
		in_data_t d;
		raw   = {$urandom, $urandom, $urandom};
		d     = raw[IN_DATA_W-1:0];
		d.pad = '0;
		return d;
	endfunction

	function automatic logic [TIME_W-1:0] rand_time();
		case ($urandom_range(0, 3))
			0:       return TIME_W'($urandom_range(0, 4095));
			1:       return 32'hFFFF_FFFF - TIME_W'($urandom_range(0, 1023));
			default: return $urandom;
		endcase
	endfunction

	function automatic int rand_symbol();
		if ($urandom_range(0, 1) == 0)
			return DARKEST_CHAR + $urandom_range(0, 25);
		return $urandom_range(0, 255);
	endfunction

	function automatic int rand_slot();
		if ($urandom_range(0, 9) < 7)
			return $urandom_range(0, 7);
		return $urandom_range(0, SLOTS - 1);
	endfunction

	// Mostly short patterns, a few long ones, now and then one that is rejected
	function automatic int rand_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return 0;
		if (r < 88)
			return $urandom_range(1, 8);
		if (r < 96)
			return $urandom_range(9, PATTERN_MAX - 2);
		return PATTERN_MAX - 1;
	endfunction

	// Offer one beat, with an optional idle burst in front
	task automatic send(logic [OP_W-1:0] op, in_data_t d);
		int gap, miss;
		if (tx_phase == 0) begin
			tx_phase = $urandom_range(10, 80);
			tx_calm  = ($urandom_range(0, 2) == 0);
		end
		tx_phase--;
		if (!quiet && !tx_calm && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 13);
			s_tvalid <= 1'b0;
			s_tdata  <= rand_fields();
			repeat (gap) @(posedge clk);
		end
		// never read a pattern character that was not written yet
		if (op == OP_EVAL) begin
			miss = board.missing_char(d.slot);
			if (miss >= 0) begin
				op         = OP_WRITE;
				d.position = POS_W'(miss);
			end
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= d;
		do @(posedge clk); while (s_tready !== 1'b1);
		board.note(op, d);
		beats++;
		if (op != OP_NONE && !(op == OP_HEADER && int'(d.pattern_length) >= PATTERN_MAX - 1))
			sent++;
	endtask

	task automatic put_char(int s, int p, int c);
		in_data_t d;
		d          = rand_fields();
		d.slot     = SLOT_W'(s);
		d.position = POS_W'(p);
		d.symbol   = SYM_W'(c);
		send(OP_WRITE, d);
	endtask

	task automatic put_header(int s, int len, int rate, bit bl);
		in_data_t d;
		d                = rand_fields();
		d.slot           = SLOT_W'(s);
		d.pattern_length = LEN_W'(len);
		d.frame_rate     = RATE_W'(rate);
		d.blend          = bl;
		send(OP_HEADER, d);
	endtask

	task automatic put_eval(int s, logic [TIME_W-1:0] t);
		in_data_t d;
		d          = rand_fields();
		d.slot     = SLOT_W'(s);
		d.time_now = t;
		send(OP_EVAL, d);
	endtask

	// Sender pause until every owed result has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (board.owed.size() != 0);
	endtask

	initial begin : stimulus
		int pick, s, len, rate;
		bit drained;
		in_data_t d;
		drained  = 1'b0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser  <= '0;
		s_tdata  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// undefined slot reads dark
		put_eval(0, 32'h0000_1234);
		// length zero: constant full brightness
		put_header(1, 0, 0, 1'b0);
		put_eval(1, 32'hFFFF_FFFF);
		// blended three-step pattern with the symbol extremes at the default rate
		put_char(2, 0, 0);
		put_char(2, 1, 255);
		put_char(2, 2, DARKEST_CHAR);
		put_header(2, 3, 0, 1'b1);
		put_eval(2, 32'd0);
		put_eval(2, 32'd51);
		put_eval(2, 32'd5);
		put_eval(2, 32'hFFFF_FFFF);
		// too-long header is dropped, slot 2 keeps blending
		put_header(2, PATTERN_MAX - 1, 7, 1'b0);
		put_eval(2, 32'd100);
		// last slot, last position, stepped at the highest rate
		put_char(63, 63, 255);
		put_char(63, 0, DARKEST_CHAR + 25);
		put_header(63, 1, 255, 1'b0);
		put_eval(63, 32'hFFFF_FFFF);
		// longest accepted header
		put_header(3, PATTERN_MAX - 2, 1, 1'b1);
		// reserved operation code
		send(OP_NONE, rand_fields());
		put_eval(2, 32'h8000_0000);

		while (sent < RANDOM_ITEMS) begin
			if (!drained && sent >= RANDOM_ITEMS / 2) begin
				drain();
				drained = 1'b1;
			end
			if (RANDOM_ITEMS - sent < TAIL_ITEMS)
				quiet = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				// well-formed program: header, full pattern, then a few evaluates
				s    = rand_slot();
				len  = rand_len();
				rate = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 255);
				put_header(s, len, rate, 1'($urandom_range(0, 1)));
				if (len < PATTERN_MAX - 1)
					for (int p = 0; p < len; p++)
						put_char(s, p, rand_symbol());
				repeat ($urandom_range(2, 6)) put_eval(s, rand_time());
			end else if (pick < 85) begin
				put_eval(rand_slot(), rand_time());
			end else if (pick < 96) begin
				d = rand_fields();
				send(OP_W'($urandom_range(0, 2)), d);
			end else begin
				send(OP_NONE, rand_fields());
			end
		end

		s_tvalid <= 1'b0;
		do @(posedge clk); while (board.owed.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d input beats and %0d checked results", beats, board.checked);
		$display("  evaluates: %0d undefined, %0d empty, %0d stepped, %0d blended",
			board.n_dark, board.n_full, board.n_step, board.n_blend);
		if (board.errors == 0 && board.owed.size() == 0)
			$display("** light_pattern_animator: PASSED **");
		else
			$display("** light_pattern_animator: FAILED **");
		$finish;
	end
endmodule
